// File: src/imel_pkg.sv
package imel_pkg;

  localparam int          LOG_FB    = 30;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] EPS_RESET = 32'd4295;
  localparam logic [31:0] OUT_MAX   = 32'hFFFF_FFFF;

  // register index, taken from paddr[2]
  localparam logic REG_EPSILON = 1'b0;

  // state carried along the root/log chain
  typedef struct packed {
    logic        valid;
    logic [65:0] rad;     // radicand, consumed two bits per cell
    logic [34:0] rem;
    logic [32:0] root;
    logic [31:0] m_max;   // Q1.31 mantissas
    logic [31:0] m_min;
    logic [29:0] f_max;   // log2 fraction bits
    logic [29:0] f_min;
    logic [4:0]  k_max;
    logic [4:0]  k_min;
    logic [31:0] h1;
    logic [31:0] d;
    logic        plain;
    logic        zero;
  } root_st_t;

  // state carried along the divider chain; divisor sized for the smallest FRAC_BITS (8)
  typedef struct packed {
    logic        valid;
    logic        sat;
    logic [54:0] rem;
    logic [31:0] num_lo;
    logic [53:0] dvs;
    logic [31:0] q;
  } div_st_t;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] df;
    logic        [32:0] ng;
    df = $signed({b[31], b}) - $signed({a[31], a});
    ng = -df;
    return df[32] ? ng[31:0] : df[31:0];
  endfunction

  function automatic logic [4:0] lead_one(input logic [31:0] x);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) k = 5'(i);
    end
    return k;
  endfunction

endpackage

// File: src/imel_root_cell.sv
module imel_root_cell #(
  parameter bit DO_LOG = 1'b1
) (
  input  logic              clk,
  input  logic              rst,
  input  imel_pkg::root_st_t st_in,
  output imel_pkg::root_st_t st_out
);
  import imel_pkg::*;

  logic [36:0] rem_sh;
  logic [36:0] trial;
  logic [63:0] sq_max, sq_min;
  logic [32:0] ms_max, ms_min;

  // one bit of the square root
  assign rem_sh = {st_in.rem, st_in.rad[65:64]};
  assign trial  = {2'b00, st_in.root, 2'b01};

  // one fraction bit of each log2 by squaring
  assign sq_max = st_in.m_max * st_in.m_max;
  assign sq_min = st_in.m_min * st_in.m_min;
  assign ms_max = sq_max[63:31];
  assign ms_min = sq_min[63:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_out.valid <= 1'b0;
    end else begin
      st_out.valid <= st_in.valid;
    end
    st_out.rad   <= {st_in.rad[63:0], 2'b00};
    if (rem_sh >= trial) begin
      st_out.rem  <= 35'(rem_sh - trial);
      st_out.root <= {st_in.root[31:0], 1'b1};
    end else begin
      st_out.rem  <= rem_sh[34:0];
      st_out.root <= {st_in.root[31:0], 1'b0};
    end
    if (DO_LOG) begin
      st_out.m_max <= ms_max[32] ? ms_max[32:1] : ms_max[31:0];
      st_out.m_min <= ms_min[32] ? ms_min[32:1] : ms_min[31:0];
      st_out.f_max <= {st_in.f_max[28:0], ms_max[32]};
      st_out.f_min <= {st_in.f_min[28:0], ms_min[32]};
    end else begin
      st_out.m_max <= st_in.m_max;
      st_out.m_min <= st_in.m_min;
      st_out.f_max <= st_in.f_max;
      st_out.f_min <= st_in.f_min;
    end
    st_out.k_max <= st_in.k_max;
    st_out.k_min <= st_in.k_min;
    st_out.h1    <= st_in.h1;
    st_out.d     <= st_in.d;
    st_out.plain <= st_in.plain;
    st_out.zero  <= st_in.zero;
  end

endmodule

// File: src/imel_div_cell.sv
module imel_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  imel_pkg::div_st_t st_in,
  output imel_pkg::div_st_t st_out
);
  import imel_pkg::*;

  logic [54:0] r;
  logic [54:0] dv;

  assign r  = {st_in.rem[53:0], st_in.num_lo[31]};
  assign dv = {1'b0, st_in.dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      st_out.valid <= 1'b0;
    end else begin
      st_out.valid <= st_in.valid;
    end
    st_out.sat    <= st_in.sat;
    st_out.dvs    <= st_in.dvs;
    st_out.num_lo <= {st_in.num_lo[30:0], 1'b0};
    if (r >= dv) begin
      st_out.rem <= r - dv;
      st_out.q   <= {st_in.q[30:0], 1'b1};
    end else begin
      st_out.rem <= r;
      st_out.q   <= {st_in.q[30:0], 1'b0};
    end
  end

endmodule

// File: src/iso_metric_edge_length_core.sv
// Throughput: one transaction per cycle; busy is held low, so start is always taken.
// The pipeline runs through the 33-cell square-root/log chain and the 32-cell divider chain.
// The receiver cannot stall: each result shows for a single cycle with done.
// Synchronous active-high reset empties the pipeline and loads ratio_epsilon with 4295.
module iso_metric_edge_length_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [31:0] point_a_x,
  input  logic [31:0] point_a_y,
  input  logic [31:0] point_a_z,
  input  logic [31:0] point_b_x,
  input  logic [31:0] point_b_y,
  input  logic [31:0] point_b_z,
  input  logic [31:0] size_a,
  input  logic [31:0] size_b,
  // result channel
  output logic        done,
  output logic [31:0] metric_length,
  output logic        saturated,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import imel_pkg::*;

  localparam int NROOT = 33;
  localparam int NDIV  = 32;

  // ---------------- configuration ----------------
  logic [31:0] ratio_epsilon;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr[2] == REG_EPSILON) ? ratio_epsilon : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_epsilon <= EPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EPSILON) begin
      ratio_epsilon <= pwdata;
    end
  end

  // ---------------- stage 1: differences, size ordering ----------------
  logic        v1;
  logic [31:0] mx1, my1, mz1, h1_1, d1, hmax1, hmin1;
  logic        zero1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mx1   <= abs_diff(point_a_x, point_b_x);
    my1   <= abs_diff(point_a_y, point_b_y);
    mz1   <= abs_diff(point_a_z, point_b_z);
    h1_1  <= size_a;
    zero1 <= (size_a == 32'd0) || (size_b == 32'd0);
    if (size_b > size_a) begin
      d1    <= size_b - size_a;
      hmax1 <= size_b;
      hmin1 <= size_a;
    end else begin
      d1    <= size_a - size_b;
      hmax1 <= size_a;
      hmin1 <= size_b;
    end
  end

  // ---------------- stage 2: squares, epsilon product, normalisation ----------------
  logic        v2;
  logic [63:0] sx2, sy2, sz2, ep2;
  logic [31:0] h1_2, d2, mmax2, mmin2;
  logic [4:0]  kmax2, kmin2;
  logic        zero2;
  logic [4:0]  kmax_c, kmin_c;

  assign kmax_c = lead_one(hmax1);
  assign kmin_c = lead_one(hmin1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    sx2   <= mx1 * mx1;
    sy2   <= my1 * my1;
    sz2   <= mz1 * mz1;
    ep2   <= ratio_epsilon * h1_1;
    kmax2 <= kmax_c;
    kmin2 <= kmin_c;
    mmax2 <= hmax1 << (5'd31 - kmax_c);
    mmin2 <= hmin1 << (5'd31 - kmin_c);
    h1_2  <= h1_1;
    d2    <= d1;
    zero2 <= zero1;
  end

  // ---------------- stage 3: sum of squares, branch choice ----------------
  root_st_t rs [NROOT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rs[0].valid <= 1'b0;
    end else begin
      rs[0].valid <= v2;
    end
    rs[0].rad   <= 66'(sx2) + 66'(sy2) + 66'(sz2);
    rs[0].rem   <= '0;
    rs[0].root  <= '0;
    rs[0].m_max <= mmax2;
    rs[0].m_min <= mmin2;
    rs[0].f_max <= '0;
    rs[0].f_min <= '0;
    rs[0].k_max <= kmax2;
    rs[0].k_min <= kmin2;
    rs[0].h1    <= h1_2;
    rs[0].d     <= d2;
    // near-equal sizes take the plain division
    rs[0].plain <= (d2 == 32'd0) || ({d2, 32'd0} < ep2);
    rs[0].zero  <= zero2;
  end

  // root / log chain: one root bit per cell, one log bit in each of the first 30 cells
  for (genvar i = 0; i < NROOT; i++) begin : g_root
    imel_root_cell #(
      .DO_LOG (i < LOG_FB)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .st_in  (rs[i]),
      .st_out (rs[i+1])
    );
  end

  // ---------------- post stage A: log difference ----------------
  logic        va;
  logic [34:0] dl_a;
  logic [32:0] l_a;
  logic [31:0] h1_a, d_a;
  logic        plain_a, zero_a;
  logic [34:0] lmax_c, lmin_c;

  assign lmax_c = {rs[NROOT].k_max, rs[NROOT].f_max};
  assign lmin_c = {rs[NROOT].k_min, rs[NROOT].f_min};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= rs[NROOT].valid;
    end
  end

  always_ff @(posedge clk) begin
    dl_a    <= (lmax_c >= lmin_c) ? lmax_c - lmin_c : 35'd0;
    l_a     <= rs[NROOT].root;
    h1_a    <= rs[NROOT].h1;
    d_a     <= rs[NROOT].d;
    plain_a <= rs[NROOT].plain;
    zero_a  <= rs[NROOT].zero;
  end

  // ---------------- post stage B: natural log, Q.30 ----------------
  logic        vb;
  logic [34:0] lnq_b;
  logic [32:0] l_b;
  logic [31:0] h1_b, d_b;
  logic        plain_b, zero_b;
  logic [66:0] ln_prod;

  assign ln_prod = dl_a * LN2_Q32;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    lnq_b   <= ln_prod[66:32];
    l_b     <= l_a;
    h1_b    <= h1_a;
    d_b     <= d_a;
    plain_b <= plain_a;
    zero_b  <= zero_a;
  end

  // ---------------- post stage C: numerator and divisor ----------------
  logic        vc;
  logic [67:0] num_c;
  logic [53:0] dvs_c;
  logic        zero_c;
  logic [34:0] mul_c;

  assign mul_c = plain_b ? (35'd1 << FRAC_BITS) : lnq_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    num_c  <= l_b * mul_c;
    dvs_c  <= plain_b ? 54'(h1_b) : (54'(d_b) << (LOG_FB - FRAC_BITS));
    zero_c <= zero_b;
  end

  // ---------------- post stage D: overflow test, divider load ----------------
  div_st_t ds [NDIV+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ds[0].valid <= 1'b0;
    end else begin
      ds[0].valid <= vc;
    end
    // quotient of 2^32 or more saturates
    ds[0].sat    <= zero_c || (86'(num_c) >= {dvs_c, 32'd0});
    ds[0].rem    <= 55'(num_c[67:32]);
    ds[0].num_lo <= num_c[31:0];
    ds[0].dvs    <= dvs_c;
    ds[0].q      <= '0;
  end

  // ---------------- divider chain: one quotient bit per cell ----------------
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    imel_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .st_in  (ds[j]),
      .st_out (ds[j+1])
    );
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ds[NDIV].valid;
    end
  end

  always_ff @(posedge clk) begin
    metric_length <= ds[NDIV].sat ? OUT_MAX : ds[NDIV].q;
    saturated     <= ds[NDIV].sat;
  end

endmodule

// File: src/iso_metric_edge_length_chk.sv
module iso_metric_edge_length_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] metric_length,
  input logic        saturated,
  input logic        pready
);

  localparam int LAT = 73;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> metric_length == 32'hFFFF_FFFF)
    else $error("saturated result not at maximum");

  a_reset_empty: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind iso_metric_edge_length_core iso_metric_edge_length_chk u_chk (.*);

// File: verif/iso_metric_edge_length_core_tb.sv
`timescale 1ns / 100ps

module iso_metric_edge_length_core_tb;
  import imel_pkg::*;

  localparam int FRAC      = 16;
  localparam int END_WAIT  = 120;    // comfortably beyond the latency of the pipeline
  localparam int WDOG_MAX  = 4000;   // idle cycles before the run is abandoned
  localparam logic [2:0] ADDR_EPSILON = 3'd0;
  localparam logic [2:0] ADDR_UNUSED  = 3'd4;

  typedef struct {
    logic [31:0] ax, ay, az, bx, by, bz;
    logic [31:0] ha, hb;
  } edge_item_t;

  typedef struct {
    logic [31:0] len;
    logic        sat;
  } edge_len_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] point_a_x = '0, point_a_y = '0, point_a_z = '0;
  logic [31:0] point_b_x = '0, point_b_y = '0, point_b_z = '0;
  logic [31:0] size_a = '0, size_b = '0;
  logic        done;
  logic [31:0] metric_length;
  logic        saturated;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  edge_item_t  pending_edges[$];
  edge_len_t   expected_lengths[$];
  logic [31:0] epsilon_shadow = EPS_RESET;
  int          fail_count = 0;
  int          gap_left = 0;
  bit          gaps_on = 1'b1;    // cleared for stretches of back-to-back traffic
  int          idle_cycles = 0;

  iso_metric_edge_length_core dut (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Length predictor
  // ---------------------------------------------------------------------------

  // floor square root of a 66-bit radicand, two bits per step
  function automatic logic [32:0] sqrt_floor(input logic [65:0] rad);
    logic [69:0] rem;
    logic [69:0] trial;
    logic [32:0] root;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 70'(rad[2*i +: 2]);
      trial = (70'(root) << 2) | 70'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 33'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // log2 of a raw non-zero size, Q5.30, by repeated squaring of the mantissa
  function automatic logic [34:0] log2_size(input logic [31:0] x);
    int          k;
    logic [63:0] m;
    logic [29:0] frac;
    k = 0;
    for (int i = 0; i < 32; i++) if (x[i]) k = i;
    m = 64'((x << (31 - k)) & 32'hFFFF_FFFF);
    frac = '0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {5'(k), frac};
  endfunction

  function automatic edge_len_t predict_length(input edge_item_t it, input logic [31:0] eps);
    logic signed [32:0] df [3];
    logic [32:0]  mag;
    logic [65:0]  sumsq;
    logic [32:0]  l;
    logic [31:0]  d;
    logic [34:0]  lmax, lmin, dl;
    logic [127:0] lnq, q;
    edge_len_t    r;
    df[0] = $signed({it.bx[31], it.bx}) - $signed({it.ax[31], it.ax});
    df[1] = $signed({it.by[31], it.by}) - $signed({it.ay[31], it.ay});
    df[2] = $signed({it.bz[31], it.bz}) - $signed({it.az[31], it.az});
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      mag = df[i][32] ? 33'(-df[i]) : 33'(df[i]);
      sumsq = sumsq + 66'(mag) * 66'(mag);
    end
    l = sqrt_floor(sumsq);
    // a zero size always saturates, even for a zero-length edge
    if (it.ha == 0 || it.hb == 0) begin
      r.len = OUT_MAX;
      r.sat = 1'b1;
      return r;
    end
    d = (it.hb > it.ha) ? it.hb - it.ha : it.ha - it.hb;
    if (d == 0 || {d, 32'd0} < 64'(eps) * 64'(it.ha)) begin
      q = (128'(l) << FRAC) / 128'(it.ha);
    end else begin
      lmax = log2_size((it.hb > it.ha) ? it.hb : it.ha);
      lmin = log2_size((it.hb > it.ha) ? it.ha : it.hb);
      dl   = (lmax >= lmin) ? lmax - lmin : '0;   // truncation may invert the order
      lnq  = (128'(dl) * 128'(LN2_Q32)) >> 32;
      q    = (128'(l) * lnq) / (128'(d) << (LOG_FB - FRAC));
    end
    if (q > 128'(OUT_MAX)) begin
      r.len = OUT_MAX;
      r.sat = 1'b1;
    end else begin
      r.len = q[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one command transaction per accepting edge, random gaps between
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    edge_item_t it;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        it.ax = point_a_x; it.ay = point_a_y; it.az = point_a_z;
        it.bx = point_b_x; it.by = point_b_y; it.bz = point_b_z;
        it.ha = size_a;    it.hb = size_b;
        expected_lengths.push_back(predict_length(it, epsilon_shadow));
      end
      if (start && busy) begin
        // held until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_edges.size() > 0) begin
        it = pending_edges.pop_front();
        point_a_x <= it.ax; point_a_y <= it.ay; point_a_z <= it.az;
        point_b_x <= it.bx; point_b_y <= it.by; point_b_z <= it.bz;
        size_a <= it.ha;    size_b <= it.hb;
        start <= 1'b1;
        if (!gaps_on) gap_left <= 0;
        else if ($urandom_range(0, 99) < 55) gap_left <= 0;
        else if ($urandom_range(0, 99) < 85) gap_left <= $urandom_range(1, 3);
        else gap_left <= $urandom_range(10, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and watchdog: results cannot be held off, so every done is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    edge_len_t e;
    if (!rst) begin
      if (done) begin
        if (expected_lengths.size() == 0) begin
          $error("unexpected result transaction: metric_length %h", metric_length);
          fail_count++;
        end else begin
          e = expected_lengths.pop_front();
          if (metric_length !== e.len) begin
            $error("metric_length expected %h actual %h", e.len, metric_length);
            fail_count++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, saturated);
            fail_count++;
          end
        end
      end
      if (done || (start && !busy) || psel) idle_cycles <= 0;
      else if (idle_cycles >= WDOG_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access, only while the pipeline is empty
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_EPSILON) epsilon_shadow = val;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic apb_check_epsilon();
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_EPSILON;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== epsilon_shadow) begin
      $error("ratio_epsilon expected %h actual %h", epsilon_shadow, prdata);
      fail_count++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic drain();
    while (pending_edges.size() > 0 || start || expected_lengths.size() > 0)
      @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_edge(input logic [31:0] ax, ay, az, bx, by, bz, ha, hb);
    edge_item_t it;
    it.ax = ax; it.ay = ay; it.az = az; it.bx = bx; it.by = by; it.bz = bz;
    it.ha = ha; it.hb = hb;
    pending_edges.push_back(it);
  endtask

  function automatic logic [31:0] rand_size();
    int sh;
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 3);
      default: begin
        sh = $urandom_range(0, 31);
        return ($urandom() >> sh) | 32'd1;
      end
    endcase
  endfunction

  // well-formed edges mostly: a random base point with an offset of random scale
  task automatic push_random_edge(input logic [31:0] eps);
    logic [31:0] base [3];
    logic [31:0] pb [3];
    logic [31:0] ha, hb;
    int sh;
    for (int i = 0; i < 3; i++) begin
      base[i] = $urandom();
      sh = $urandom_range(0, 31);
      pb[i] = ($urandom_range(0, 9) == 0) ? $urandom()
                                           : base[i] + (32'($signed($urandom())) >>> sh);
    end
    ha = rand_size();
    case ($urandom_range(0, 5))
      0: hb = ha;                                          // plain branch
      1: hb = ha + (ha >> $urandom_range(18, 31));         // around the epsilon edge
      2: hb = ha - (ha >> $urandom_range(18, 31));
      default: hb = rand_size();
    endcase
    push_edge(base[0], base[1], base[2], pb[0], pb[1], pb[2], ha, hb);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      push_random_edge(epsilon_shadow);
    end
    drain();
    gaps_on = 1'b1;
  endtask

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_check_epsilon();   // reset value

    // directed edges at the reset epsilon
    push_edge(0, 0, 0, 0, 0, 0, ONE, ONE);                 // zero length
    push_edge(0, 0, 0, 0, 0, 0, 0, ONE);                   // zero size, zero length
    push_edge(0, 0, 0, ONE, 0, 0, ONE, 0);                 // zero second size
    push_edge(0, 0, 0, ONE, ONE, ONE, ONE, ONE);           // unit cube diagonal
    push_edge(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, ONE, ONE);  // longest edge, overflow
    push_edge(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, OUT_MAX, OUT_MAX);
    push_edge(SMIN, 0, SMAX, SMAX, 0, SMIN, OUT_MAX, 32'd1);  // log branch, extreme ratio
    push_edge(0, 0, 0, ONE, 0, 0, ONE, 2 * ONE);           // ratio two
    push_edge(0, 0, 0, ONE, 0, 0, 2 * ONE, ONE);           // ratio one half
    push_edge(0, 0, 0, 3 * ONE, 4 * ONE, 0, ONE, ONE + 1); // just past epsilon
    push_edge(0, 0, 0, 3 * ONE, 4 * ONE, 0, OUT_MAX, OUT_MAX - 1);  // within epsilon
    push_edge(0, 0, 0, 0, 0, 1, 32'd1, 32'd1);             // smallest sizes
    push_edge(0, 0, 0, 0, 0, 1, 32'd1, 32'd2);
    push_edge(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 32'd3, 32'd5);
    push_edge(ONE, ONE, ONE, ONE, ONE, ONE, 32'd7, 32'd9);  // zero length, log branch
    push_edge(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, 32'hAAAA_AAAA, 32'h5555_5555);
    drain();
    run_random(80);

    // epsilon of zero: only equal sizes take the plain branch
    apb_write(ADDR_EPSILON, 32'd0);
    apb_check_epsilon();
    push_edge(0, 0, 0, ONE, 0, 0, ONE, ONE);
    push_edge(0, 0, 0, ONE, 0, 0, ONE, ONE + 1);
    drain();
    run_random(80);

    // widest epsilon: ratios below one all take the plain branch
    apb_write(ADDR_EPSILON, 32'hFFFF_FFFF);
    apb_check_epsilon();
    run_random(80);

    // writes to the unused index must leave epsilon alone
    apb_write(ADDR_EPSILON, 32'h8000_0000);
    apb_write(ADDR_UNUSED, 32'h1234_5678);
    apb_check_epsilon();
    run_random(80);

    apb_write(ADDR_EPSILON, $urandom());
    apb_check_epsilon();
    run_random(80);

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
